/* hw/rtl/hrv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrv_pkg
// shared constants, types and codes of the heightmap ray visibility core
// ----------------------------------------------------------------------------
package hrv_pkg;

  localparam int MAP_WIDTH     = 64;
  localparam int MAP_HEIGHT    = 64;
  localparam int HEIGHT_BITS   = 8;
  localparam int FRACTION_BITS = 8;

  localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = $clog2((MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT) + 2;

  localparam int ACTION_W = 2;
  localparam int COORD_W  = 6;
  localparam int HVAL_W   = 8;
  localparam int DIR_W    = 16;
  localparam int POS_W    = 14;
  localparam int EYEZ_W   = 16;
  localparam int LEN_W    = 8;
  localparam int COUNT_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIST_W     = 32;
  localparam int DIST_SHIFT = 16;
  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam int MAG_W      = DIR_W;
  localparam int OFF_W      = FRACTION_BITS + 1;
  localparam int RECIP_BITS = 31;
  localparam int DIVCNT_W   = $clog2(RECIP_BITS);
  localparam int HZ_W       = EYEZ_W + 2;
  localparam int HL_W       = DIST_W + 1;
  localparam int PROD_W     = HL_W + HZ_W;
  localparam logic signed [HZ_W-1:0] HZ_INIT = HZ_W'(-(2 ** FRACTION_BITS));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [ACTION_W-1:0] {
    OP_WR_HEIGHT = 2'd0,
    OP_CAST      = 2'd1,
    OP_READ      = 2'd2,
    OP_WR_FOG    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_X   = 2'd0,
    CFG_EYE_Y   = 2'd1,
    CFG_EYE_Z   = 2'd2,
    CFG_RAY_LEN = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM,
    ST_DIV,
    ST_START,
    ST_STEP,
    ST_FETCH,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic                    in_map;
    logic [ADDR_W-1:0]       idx;
    logic [HEIGHT_BITS-1:0]  height;
    logic                    fog;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  eye_x;
    logic [POS_W-1:0]  eye_y;
    logic [EYEZ_W-1:0] eye_z;
    logic [LEN_W-1:0]  ray_len;
  } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/hrv_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrv channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface hrv_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [5:0]        cell_x;
  logic [5:0]        cell_y;
  logic [7:0]        height_value;
  logic              fog_value;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;

  modport source (
    output valid, action, cell_x, cell_y, height_value, fog_value, dir_x, dir_y,
    input  ready
  );
  modport sink (
    input  valid, action, cell_x, cell_y, height_value, fog_value, dir_x, dir_y,
    output ready
  );
endinterface

interface hrv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_height;
  logic       read_fog;
  logic [7:0] cells_cleared;
  logic       ray_skipped;

  modport source (
    output valid, read_height, read_fog, cells_cleared, ray_skipped,
    input  ready
  );
  modport sink (
    input  valid, read_height, read_fog, cells_cleared, ray_skipped,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/hrv_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrv_ram
// generic single write, single read port memory with registered read data
// ----------------------------------------------------------------------------
module hrv_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/hrv_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrv_front
// accepts request beats, decodes them into commands and queues them
// ----------------------------------------------------------------------------
module hrv_front import hrv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hrv_in_if.sink     in_i,
  input  wire logic  hold_i,
  output logic       q_valid_o,
  output cmd_t       q_cmd_o,
  input  wire logic  q_pop_i
);

  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              cmd;

  // classify
  always_comb begin
    cmd.op     = op_e'(in_i.action);
    cmd.in_map = (32'(in_i.cell_x) < 32'(MAP_WIDTH)) && (32'(in_i.cell_y) < 32'(MAP_HEIGHT));
    cmd.idx    = ADDR_W'(in_i.cell_y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(in_i.cell_x);
    cmd.height = in_i.height_value[HEIGHT_BITS-1:0];
    cmd.fog    = in_i.fog_value;
    cmd.dir_x  = in_i.dir_x;
    cmd.dir_y  = in_i.dir_y;
  end

  assign in_i.ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH)) && !hold_i;
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = cnt_q != '0;
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = q_mem_q[rptr_q];

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cmd;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/hrv_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrv_back
// executes queued commands: map access, reciprocal unit and ray walk
// ----------------------------------------------------------------------------
module hrv_back import hrv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      clearing_o,
  hrv_out_if.source out_o
);

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic                   h_we;
  logic [ADDR_W-1:0]      h_waddr, h_raddr;
  logic [HEIGHT_BITS-1:0] h_wdata, h_rdata;
  logic                   f_we;
  logic [ADDR_W-1:0]      f_waddr, f_raddr;
  logic                   f_wdata, f_rdata;

  logic                          inside_q, inside_d;
  logic [1:0]                    neg_q, neg_d;
  logic [1:0][MAG_W-1:0]         mag_q, mag_d;
  logic [1:0][OFF_W-1:0]         off_q, off_d;
  logic [1:0][DIST_W-1:0]        step_q, step_d;
  logic [1:0][DIST_W-1:0]        t_q, t_d;
  logic [1:0][CELL_W-1:0]        cell_q, cell_d;
  logic                          ax_q, ax_d;
  logic [DIVCNT_W-1:0]           div_cnt_q, div_cnt_d;
  logic [MAG_W-1:0]              rem_q, rem_d;
  logic [RECIP_BITS-2:0]         quo_q, quo_d;
  logic [DIST_W-1:0]             cl_q, cl_d;
  logic signed [HL_W-1:0]        hl_q, hl_d;
  logic signed [HZ_W-1:0]        hz_q, hz_d;
  logic signed [HZ_W-1:0]        cz_q, cz_d;
  logic [ADDR_W-1:0]             idx_q, idx_d;
  logic                          fog_q, fog_d;
  logic signed [PROD_W-1:0]      p1_q, p1_d, p2_q, p2_d;
  logic [COUNT_W-1:0]            cleared_q, cleared_d;
  logic                          skipped_q, skipped_d;
  logic [HEIGHT_BITS-1:0]        rd_height_q, rd_height_d;
  logic                          rd_fog_q, rd_fog_d;

  logic                   out_valid_q, out_valid_d;
  logic [7:0]             o_height_q, o_height_d;
  logic                   o_fog_q, o_fog_d;
  logic [COUNT_W-1:0]     o_cleared_q, o_cleared_d;
  logic                   o_skipped_q, o_skipped_d;

  hrv_ram #(.Width(HEIGHT_BITS), .Depth(CELL_COUNT)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  hrv_ram #(.Width(1), .Depth(CELL_COUNT)) u_fog_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  assign clearing_o          = state_q == ST_CLEAR;
  assign out_o.valid         = out_valid_q;
  assign out_o.read_height   = o_height_q;
  assign out_o.read_fog      = o_fog_q;
  assign out_o.cells_cleared = o_cleared_q;
  assign out_o.ray_skipped   = o_skipped_q;

  always_comb begin
    logic [1:0][DIR_W-1:0]     dir;
    logic [1:0][POS_W-1:0]     pos;
    logic [1:0][CELL_W-1:0]    ncell;
    logic [1:0][CELL_W-1:0]    cend;
    logic [1:0]                skip;
    logic [MAG_W:0]            rem_sh;
    logic                      qbit;
    logic [OFF_W+DIST_W-1:0]   prod;
    logic [DIST_W:0]           sh;
    logic [DIST_W:0]           sum;
    logic                      sel;
    logic [ADDR_W-1:0]         nidx;
    logic signed [HZ_W-1:0]    cz;
    logic [DIST_W-1:0]         limit;

    state_d     = state_q;
    clr_d       = clr_q;
    inside_d    = inside_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    off_d       = off_q;
    step_d      = step_q;
    t_d         = t_q;
    cell_d      = cell_q;
    ax_d        = ax_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cl_d        = cl_q;
    hl_d        = hl_q;
    hz_d        = hz_q;
    cz_d        = cz_q;
    idx_d       = idx_q;
    fog_d       = fog_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    cleared_d   = cleared_q;
    skipped_d   = skipped_q;
    rd_height_d = rd_height_q;
    rd_fog_d    = rd_fog_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_height_d  = o_height_q;
    o_fog_d     = o_fog_q;
    o_cleared_d = o_cleared_q;
    o_skipped_d = o_skipped_q;

    q_pop_o = 1'b0;
    h_we    = 1'b0;
    h_waddr = q_cmd_i.idx;
    h_wdata = q_cmd_i.height;
    h_raddr = q_cmd_i.idx;
    f_we    = 1'b0;
    f_waddr = q_cmd_i.idx;
    f_wdata = q_cmd_i.fog;
    f_raddr = q_cmd_i.idx;

    dir[0] = q_cmd_i.dir_x;
    dir[1] = q_cmd_i.dir_y;
    pos[0] = cfg_i.eye_x;
    pos[1] = cfg_i.eye_y;
    skip[0] = 32'(pos[0][POS_W-1:FRACTION_BITS]) >= 32'(MAP_WIDTH);
    skip[1] = 32'(pos[1][POS_W-1:FRACTION_BITS]) >= 32'(MAP_HEIGHT);
    cend[0] = neg_q[0] ? '1 : CELL_W'(MAP_WIDTH);
    cend[1] = neg_q[1] ? '1 : CELL_W'(MAP_HEIGHT);
    ncell    = cell_q;
    rem_sh   = {rem_q, div_cnt_q == DIVCNT_W'(RECIP_BITS - 1)};
    qbit     = rem_sh >= {1'b0, mag_q[ax_q]};
    prod     = '0;
    sh       = '0;
    sel      = !(t_q[0] < t_q[1]);
    sum      = {1'b0, t_q[sel]} + {1'b0, step_q[sel]};
    nidx     = '0;
    cz       = HZ_W'({h_rdata, FRACTION_BITS'(0)}) - HZ_W'(cfg_i.eye_z);
    limit    = DIST_W'({cfg_i.ray_len, DIST_SHIFT'(0)});

    unique case (state_q)
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_q;
        f_wdata = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          inside_d    = q_cmd_i.in_map;
          rd_height_d = '0;
          rd_fog_d    = 1'b0;
          cleared_d   = '0;
          skipped_d   = 1'b0;
          unique case (q_cmd_i.op)
            OP_WR_HEIGHT: begin
              h_we    = q_cmd_i.in_map;
              state_d = ST_DONE;
            end
            OP_WR_FOG: begin
              f_we    = q_cmd_i.in_map;
              state_d = ST_DONE;
            end
            OP_READ: begin
              state_d = ST_MEM;
            end
            OP_CAST: begin
              if (skip[0] || skip[1]) begin
                skipped_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                for (int i = 0; i < 2; i++) begin
                  neg_d[i]  = dir[i][DIR_W-1];
                  mag_d[i]  = neg_d[i] ? MAG_W'(0) - dir[i] : dir[i];
                  off_d[i]  = neg_d[i] ? OFF_W'(pos[i][FRACTION_BITS-1:0])
                                       : OFF_W'(2 ** FRACTION_BITS)
                                         - OFF_W'(pos[i][FRACTION_BITS-1:0]);
                  cell_d[i] = CELL_W'(pos[i][POS_W-1:FRACTION_BITS]);
                end
                ax_d      = 1'b0;
                div_cnt_d = DIVCNT_W'(RECIP_BITS - 1);
                rem_d     = '0;
                quo_d     = '0;
                state_d   = ST_DIV;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MEM: begin
        if (inside_q) begin
          rd_height_d = h_rdata;
          rd_fog_d    = f_rdata;
        end
        state_d = ST_DONE;
      end
      ST_DIV: begin
        // one quotient bit of 2^30 / |dir| per cycle
        if (mag_q[ax_q] == '0 || div_cnt_q == '0) begin
          step_d[ax_q] = (mag_q[ax_q] == '0) ? DIST_INF : DIST_W'({quo_q, qbit});
          rem_d        = '0;
          quo_d        = '0;
          div_cnt_d    = DIVCNT_W'(RECIP_BITS - 1);
          ax_d         = 1'b1;
          if (ax_q) begin
            state_d = ST_START;
          end
        end else begin
          rem_d     = qbit ? MAG_W'(rem_sh - {1'b0, mag_q[ax_q]}) : MAG_W'(rem_sh);
          quo_d     = {quo_q[RECIP_BITS-3:0], qbit};
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end
      ST_START: begin
        for (int i = 0; i < 2; i++) begin
          prod = (OFF_W+DIST_W)'(off_q[i]) * (OFF_W+DIST_W)'(step_q[i]);
          sh   = prod[OFF_W+DIST_W-1:FRACTION_BITS];
          if (mag_q[i] == '0 || sh[DIST_W]) begin
            t_d[i] = DIST_INF;
          end else begin
            t_d[i] = sh[DIST_W-1:0];
          end
        end
        hl_d    = '0;
        hz_d    = HZ_INIT;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cl_d       = t_q[sel];
        ncell[sel] = cell_q[sel] + (neg_q[sel] ? '1 : CELL_W'(1));
        cell_d     = ncell;
        t_d[sel]   = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
        nidx       = ADDR_W'(ncell[1]) * ADDR_W'(MAP_WIDTH) + ADDR_W'(ncell[0]);
        h_raddr    = nidx;
        f_raddr    = nidx;
        idx_d      = nidx;
        if (ncell[sel] == cend[sel]) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cz_d    = cz;
        fog_d   = f_rdata;
        p1_d    = PROD_W'($signed({1'b0, cl_q})) * PROD_W'(hz_q);
        p2_d    = PROD_W'(hl_q) * PROD_W'(cz);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (p1_q < p2_q) begin
          hl_d    = $signed({1'b0, cl_q});
          hz_d    = cz_q;
          f_we    = 1'b1;
          f_waddr = idx_q;
          f_wdata = 1'b0;
          if (fog_q && cleared_q != '1) begin
            cleared_d = cleared_q + 1'b1;
          end
        end
        state_d = (cl_q < limit) ? ST_STEP : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          o_height_d  = 8'(rd_height_q);
          o_fog_d     = rd_fog_q;
          o_cleared_d = cleared_q;
          o_skipped_d = skipped_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q    <= inside_d;
    neg_q       <= neg_d;
    mag_q       <= mag_d;
    off_q       <= off_d;
    step_q      <= step_d;
    t_q         <= t_d;
    cell_q      <= cell_d;
    ax_q        <= ax_d;
    div_cnt_q   <= div_cnt_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cl_q        <= cl_d;
    hl_q        <= hl_d;
    hz_q        <= hz_d;
    cz_q        <= cz_d;
    idx_q       <= idx_d;
    fog_q       <= fog_d;
    p1_q        <= p1_d;
    p2_q        <= p2_d;
    cleared_q   <= cleared_d;
    skipped_q   <= skipped_d;
    rd_height_q <= rd_height_d;
    rd_fog_q    <= rd_fog_d;
    o_height_q  <= o_height_d;
    o_fog_q     <= o_fog_d;
    o_cleared_q <= o_cleared_d;
    o_skipped_q <= o_skipped_d;
  end

`ifndef ASSERT_OFF
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !q_pop_o)
    else $error("command taken during fog clear pass");

  a_ray_clears_fog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && f_we) |-> (!f_wdata && f_waddr == idx_q))
    else $error("ray fog update wrong");

  a_steps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_START |-> (step_q[0] != '0 && step_q[1] != '0))
    else $error("step distance not set before start");

  a_done_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && !(cl_q < DIST_W'({cfg_i.ray_len, DIST_SHIFT'(0)})))
    |=> state_q == ST_DONE)
    else $error("walk passed length limit");
`endif

endmodule
`default_nettype wire

/* hw/rtl/heightmap_ray_visibility_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_ray_visibility_core
// 64x64 height and fog map with line-of-sight ray casting from a set eye
// ----------------------------------------------------------------------------
// After reset the fog map is set to all fogged by a full-map sweep, during
// which no request beat is taken. Requests then go into a two-entry queue and
// are executed one at a time; every request gives exactly one result beat.
// A ray cast first forms a reciprocal step for each direction component, bit
// by bit for a non-zero one, then walks the ray cell by cell until it leaves
// the map or passes the ray length; each cell tested takes one height and fog
// memory read, one multiply pair and one horizon compare.
module heightmap_ray_visibility_core import hrv_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  hrv_in_if.sink                     in_i,
  hrv_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic q_valid, q_pop, clearing;
  cmd_t q_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_EYE_X:   cfg_d.eye_x   = cfg_data_i[POS_W-1:0];
        CFG_EYE_Y:   cfg_d.eye_y   = cfg_data_i[POS_W-1:0];
        CFG_EYE_Z:   cfg_d.eye_z   = cfg_data_i[EYEZ_W-1:0];
        CFG_RAY_LEN: cfg_d.ray_len = cfg_data_i[LEN_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye_x   <= '0;
      cfg_q.eye_y   <= '0;
      cfg_q.eye_z   <= '0;
      cfg_q.ray_len <= LEN_W'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hrv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .hold_i    (clearing),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  hrv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

/* tb/heightmap_ray_visibility_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_ray_visibility_core_tb
// Self-checking bench for the height/fog map ray caster. The bench first
// fills a square corner region of the height map, and keeps every read and
// every ray inside it by the choice of eye and ray length, so that no
// unwritten height is ever seen. It then runs a directed set and random
// traffic under several eye and ray length settings. Requests go out in
// bursts, and the result side stalls on its own pattern. Each result beat is
// checked against a line of sight predictor with its own copy of both maps.
// ----------------------------------------------------------------------------
module heightmap_ray_visibility_core_tb;
  import hrv_pkg::*;

  typedef struct {
    op_e                action;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [7:0]         height_value;
    logic               fog_value;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } map_req_t;

  typedef struct {
    logic [7:0] read_height;
    logic       read_fog;
    logic [7:0] cells_cleared;
    logic       ray_skipped;
  } map_rsp_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int FILL_SIZE      = 20;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hrv_in_if  req_if ();
  hrv_out_if rsp_if ();

  heightmap_ray_visibility_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];

  logic [7:0]  height_map[CELL_COUNT];
  logic        fog_map[CELL_COUNT];
  logic [13:0] eye_x_q, eye_y_q;
  logic [15:0] eye_z_q;
  logic [7:0]  ray_len_q;

  int  fail_count;
  int  idle_cycles;
  bit  beat_taken;
  int  burst_left, gap_left;
  int  stall_mode, stall_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] add_dist(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [7:0] walk_ray(logic [15:0] raw_x, logic [15:0] raw_y,
                                          output logic skipped);
    logic [15:0] raw[2];
    logic [13:0] pos[2];
    logic [31:0] step_d[2], t_dist[2], cl, limit;
    logic [16:0] mag;
    logic [8:0]  off;
    longint unsigned p;
    int cur_cell[2], inc[2], stop[2];
    longint hl, hz, cz;
    int ax, idx, cleared;
    raw[0] = raw_x;
    raw[1] = raw_y;
    pos[0] = eye_x_q;
    pos[1] = eye_y_q;
    skipped = 1'b0;
    hl = 0;
    hz = -256;
    cleared = 0;
    limit = {8'd0, ray_len_q, 16'd0};
    if ((pos[0] >> 8) >= MAP_WIDTH || (pos[1] >> 8) >= MAP_HEIGHT) begin
      skipped = 1'b1;
      return 8'd0;
    end
    for (int i = 0; i < 2; i++) begin
      mag = raw[i][15] ? (17'h10000 - {1'b0, raw[i]}) : {1'b0, raw[i]};
      off = raw[i][15] ? {1'b0, pos[i][7:0]} : (9'd256 - pos[i][7:0]);
      cur_cell[i] = pos[i] >> 8;
      inc[i] = raw[i][15] ? -1 : 1;
      stop[i] = raw[i][15] ? -1 : ((i == 0) ? MAP_WIDTH : MAP_HEIGHT);
      if (mag == 0) begin
        step_d[i] = 32'hFFFF_FFFF;
        t_dist[i] = 32'hFFFF_FFFF;
      end else begin
        step_d[i] = (32'd1 << 30) / mag;
        p = (longint'(off) * longint'(step_d[i])) >> 8;
        t_dist[i] = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
      end
    end
    forever begin
      ax = (t_dist[0] < t_dist[1]) ? 0 : 1;
      cl = t_dist[ax];
      cur_cell[ax] += inc[ax];
      t_dist[ax] = add_dist(t_dist[ax], step_d[ax]);
      if (cur_cell[ax] == stop[ax]) break;
      idx = cur_cell[1] * MAP_WIDTH + cur_cell[0];
      cz = (longint'(height_map[idx]) <<< 8) - longint'(eye_z_q);
      if (longint'(cl) * hz < hl * cz) begin
        hl = longint'(cl);
        hz = cz;
        if (fog_map[idx] && cleared < 255) cleared++;
        fog_map[idx] = 1'b0;
      end
      if (!(cl < limit)) break;
    end
    return cleared[7:0];
  endfunction

  function automatic map_rsp_t predict_visibility(map_req_t r);
    map_rsp_t o;
    int idx;
    logic skipped;
    o = '{default: '0};
    idx = r.cell_y * MAP_WIDTH + r.cell_x;
    case (r.action)
      OP_WR_HEIGHT: height_map[idx] = r.height_value;
      OP_WR_FOG:    fog_map[idx] = r.fog_value;
      OP_READ: begin
        o.read_height = height_map[idx];
        o.read_fog = fog_map[idx];
      end
      default: begin
        o.cells_cleared = walk_ray(r.dir_x, r.dir_y, skipped);
        o.ray_skipped = skipped;
      end
    endcase
    return o;
  endfunction

  // monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    map_rsp_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(predict_visibility(pending_reqs.pop_front()));
        beat_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.read_height !== want.read_height)
            $display("%0t: read_height exp %0d got %0d", $time, want.read_height,
                     rsp_if.read_height);
          if (rsp_if.read_fog !== want.read_fog)
            $display("%0t: read_fog exp %0d got %0d", $time, want.read_fog,
                     rsp_if.read_fog);
          if (rsp_if.cells_cleared !== want.cells_cleared)
            $display("%0t: cells_cleared exp %0d got %0d", $time, want.cells_cleared,
                     rsp_if.cells_cleared);
          if (rsp_if.ray_skipped !== want.ray_skipped)
            $display("%0t: ray_skipped exp %0d got %0d", $time, want.ray_skipped,
                     rsp_if.ray_skipped);
          if (rsp_if.read_height !== want.read_height || rsp_if.read_fog !== want.read_fog ||
              rsp_if.cells_cleared !== want.cells_cleared ||
              rsp_if.ray_skipped !== want.ray_skipped)
            fail_count++;
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[heightmap_ray_visibility_core] ERROR");
        $finish;
      end
    end
  end

  // request driver, bursts with gaps
  always @(negedge clk_i) begin
    if (req_if.valid && !beat_taken) begin
      req_if.valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      req_if.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      req_if.valid        <= 1'b1;
      req_if.action       <= pending_reqs[0].action;
      req_if.cell_x       <= pending_reqs[0].cell_x;
      req_if.cell_y       <= pending_reqs[0].cell_y;
      req_if.height_value <= pending_reqs[0].height_value;
      req_if.fog_value    <= pending_reqs[0].fog_value;
      req_if.dir_x        <= pending_reqs[0].dir_x;
      req_if.dir_y        <= pending_reqs[0].dir_y;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      req_if.valid <= 1'b0;
    end
    beat_taken = 1'b0;
  end

  // result stall pattern
  always @(negedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_count = $urandom_range(16, 200);
    end else begin
      stall_count--;
    end
    case (stall_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
      2:       rsp_if.ready <= (stall_count % 7 < 2);
      default: rsp_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic queue_req(op_e a, int x, int y, int h, int f, int dx, int dy);
    map_req_t r;
    r.action = a;
    r.cell_x = 6'(x);
    r.cell_y = 6'(y);
    r.height_value = 8'(h);
    r.fog_value = 1'(f);
    r.dir_x = 16'(dx);
    r.dir_y = 16'(dy);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, int v);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_data = 16'(v);
    case (r)
      CFG_EYE_X: eye_x_q = 14'(v);
      CFG_EYE_Y: eye_y_q = 14'(v);
      CFG_EYE_Z: eye_z_q = 16'(v);
      default:   ray_len_q = 8'(v);
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic int random_dir();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 65535) - 32768;
      2:       return ($urandom_range(0, 1) == 1) ? 16384 : -16384;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  task automatic queue_random(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 19);
      if (k < 8)
        queue_req(OP_CAST, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 1), random_dir(), random_dir());
      else if (k < 12)
        queue_req(OP_READ, $urandom_range(0, FILL_SIZE - 1), $urandom_range(0, FILL_SIZE - 1),
                  $urandom_range(0, 255), $urandom_range(0, 1), random_dir(), random_dir());
      else if (k < 15)
        queue_req(OP_WR_HEIGHT, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 1), random_dir(), random_dir());
      else
        queue_req(OP_WR_FOG, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), ($urandom_range(0, 3) != 0), random_dir(),
                  random_dir());
    end
  endtask

  initial begin
    int ex[6], ey[6], ez[6], ln[6];
    // eye cell plus twice the length plus two stays inside the filled region
    ex = '{255, 3136, 0, 2000, 300, 128};
    ey = '{0, 3136, 4095, 2300, 100, 128};
    ez = '{65535, 12800, 0, 30000, 2000, 40000};
    ln = '{0, 3, 1, 4, 8, 9};
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.action = OP_WR_HEIGHT;
    req_if.cell_x = '0;
    req_if.cell_y = '0;
    req_if.height_value = '0;
    req_if.fog_value = 1'b0;
    req_if.dir_x = '0;
    req_if.dir_y = '0;
    rsp_if.ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    beat_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_count = 0;
    eye_x_q = '0;
    eye_y_q = '0;
    eye_z_q = '0;
    ray_len_q = 8'd16;
    for (int i = 0; i < CELL_COUNT; i++) begin
      height_map[i] = '0;
      fog_map[i] = 1'b1;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the corner region that every read and ray stays within
    for (int y = 0; y < FILL_SIZE; y++)
      for (int x = 0; x < FILL_SIZE; x++)
        queue_req(OP_WR_HEIGHT, x, y, ($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 255) : $urandom_range(0, 40), 0, 0, 0);

    // directed set at reset settings, direction components of at most twice unit size
    queue_req(OP_READ, 0, 0, 0, 0, 0, 0);
    queue_req(OP_READ, 19, 19, 255, 1, -1, -1);
    queue_req(OP_WR_HEIGHT, 63, 63, 255, 0, 0, 0);
    queue_req(OP_WR_HEIGHT, 62, 0, 0, 1, 0, 0);
    queue_req(OP_READ, 63, 63, 0, 0, 0, 0);
    queue_req(OP_WR_FOG, 5, 0, 0, 0, 0, 0);
    queue_req(OP_WR_FOG, 0, 63, 0, 1, 0, 0);
    queue_req(OP_READ, 5, 0, 0, 0, 0, 0);
    queue_req(OP_CAST, 0, 0, 0, 0, 16384, 0);
    queue_req(OP_CAST, 0, 0, 0, 0, 0, 16384);
    queue_req(OP_CAST, 0, 0, 0, 0, 0, 0);
    queue_req(OP_CAST, 0, 0, 0, 0, -32768, 16384);
    queue_req(OP_CAST, 0, 0, 0, 0, -16384, -16384);
    queue_req(OP_CAST, 0, 0, 0, 0, 11585, 11585);
    queue_req(OP_CAST, 0, 0, 0, 0, 1, 16384);
    queue_req(OP_CAST, 0, 0, 0, 0, 8191, -32768);
    queue_req(OP_READ, 1, 0, 0, 0, 0, 0);
    queue_req(OP_READ, 0, 1, 0, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_EYE_X, ex[ph]);
      write_reg(CFG_EYE_Y, ey[ph]);
      write_reg(CFG_EYE_Z, ez[ph]);
      write_reg(CFG_RAY_LEN, ln[ph]);
      if (ph == 0) begin
        queue_req(OP_CAST, 0, 0, 0, 0, -16384, 16384);
        queue_req(OP_CAST, 0, 0, 0, 0, 0, 0);
        queue_req(OP_CAST, 0, 0, 0, 0, -32768, -32768);
      end
      queue_random(60);
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("[heightmap_ray_visibility_core] OK");
    end else begin
      $display("[heightmap_ray_visibility_core] ERROR");
    end
    $finish;
  end

endmodule
